// File: rtl/ndpf_pkg.sv
// Shared constants, register indexes and the per-stage control word of the point finder.
package ndpf_pkg;

  localparam int TOL_W      = 52;
  localparam int DIMS_W     = 2;
  localparam int FIELD_DIMS = 3;
  localparam int OUT_IDX_W  = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 52;

  localparam logic [DIMS_W-1:0] DIMS_RESET = 2'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TOLERANCE = 2'd0,
    REG_DIMS      = 2'd1
  } reg_idx_e;

  // Control word that travels down the chain together with each item.
  typedef struct packed {
    logic valid;
    logic last;
    logic ovf;
    logic found;
    logic live;
  } ctrl_t;

endpackage

// File: rtl/ndpf_if.sv
// Handshake interfaces for point items, result items and register writes.
interface ndpf_pt_if #(
  parameter int COORD_BITS = 24
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] coord_x;
  logic signed [COORD_BITS-1:0] coord_y;
  logic signed [COORD_BITS-1:0] coord_z;
  logic                         last_point;

  modport source (output valid, coord_x, coord_y, coord_z, last_point, input ready);
  modport sink (input valid, coord_x, coord_y, coord_z, last_point, output ready);
endinterface

interface ndpf_res_if;
  logic                           valid;
  logic                           ready;
  logic [ndpf_pkg::OUT_IDX_W-1:0] point_index;
  logic [ndpf_pkg::OUT_IDX_W-1:0] representative_index;
  logic                           set_done;
  logic                           overflow;

  modport source (output valid, point_index, representative_index, set_done, overflow,
                  input ready);
  modport sink (input valid, point_index, representative_index, set_done, overflow,
                output ready);
endinterface

interface ndpf_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [ndpf_pkg::CFG_IDX_W-1:0]  index;
  logic [ndpf_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/ndpf_match.sv
// Sums the registered squared differences of one cell and tests them against the tolerance.
module ndpf_match #(
  parameter int COORD_BITS = 24,
  parameter int STORE_DIMS = 3
) (
  input  logic [2*COORD_BITS-1:0]      sq_i [STORE_DIMS],
  input  logic [STORE_DIMS-1:0]        dim_en_i,
  input  logic [ndpf_pkg::TOL_W-1:0]   tol_i,
  output logic                         hit_o
);
  localparam int SQ_W  = 2 * COORD_BITS;
  localparam int SUM_W = SQ_W + 2;
  localparam int CMP_W = (SUM_W > ndpf_pkg::TOL_W) ? SUM_W : ndpf_pkg::TOL_W;

  logic [SUM_W-1:0] sum;
  logic [CMP_W-1:0] sum_ext;
  logic [CMP_W-1:0] tol_ext;

  always_comb begin
    sum = '0;
    for (int d = 0; d < STORE_DIMS; d++) begin
      if (dim_en_i[d]) begin
        sum = sum + SUM_W'(sq_i[d]);
      end
    end
  end

  assign sum_ext = CMP_W'(sum);
  assign tol_ext = CMP_W'(tol_i);
  assign hit_o   = (sum_ext < tol_ext);

endmodule

// File: rtl/ndpf_cell.sv
// One cell of the chain: holds one stored point, squares its distance to the passing item.
module ndpf_cell #(
  parameter int CELL_INDEX = 0,
  parameter int IDX_W      = 6,
  parameter int COORD_BITS = 24,
  parameter int STORE_DIMS = 3
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         adv_i,
  input  logic [ndpf_pkg::TOL_W-1:0]   tol_i,
  input  logic [STORE_DIMS-1:0]        dim_en_i,
  input  ndpf_pkg::ctrl_t              ctrl_i,
  input  logic [IDX_W-1:0]             idx_i,
  input  logic [IDX_W-1:0]             rep_i,
  input  logic signed [COORD_BITS-1:0] coord_i [STORE_DIMS],
  input  logic [2*COORD_BITS-1:0]      sq_i [STORE_DIMS],
  output ndpf_pkg::ctrl_t              ctrl_o,
  output logic [IDX_W-1:0]             idx_o,
  output logic [IDX_W-1:0]             rep_o,
  output logic signed [COORD_BITS-1:0] coord_o [STORE_DIMS],
  output logic [2*COORD_BITS-1:0]      sq_o [STORE_DIMS]
);
  localparam int SQ_W       = 2 * COORD_BITS;
  localparam int PREV_INDEX = (CELL_INDEX == 0) ? 0 : CELL_INDEX - 1;

  ndpf_pkg::ctrl_t              ctrl_d, ctrl_q;
  logic [IDX_W-1:0]             rep_d, idx_q, rep_q;
  logic signed [COORD_BITS-1:0] pt_q [STORE_DIMS];
  logic signed [COORD_BITS-1:0] coord_q [STORE_DIMS];
  logic [SQ_W-1:0]              sq_d [STORE_DIMS];
  logic [SQ_W-1:0]              sq_q [STORE_DIMS];
  logic                         hit;
  logic                         take;
  logic                         store_en;

  // The incoming squares belong to the previous cell, so a hit here names that cell.
  ndpf_match #(
    .COORD_BITS(COORD_BITS),
    .STORE_DIMS(STORE_DIMS)
  ) u_match (
    .sq_i    (sq_i),
    .dim_en_i(dim_en_i),
    .tol_i   (tol_i),
    .hit_o   (hit)
  );

  always_comb begin
    take         = ctrl_i.live & hit & ~ctrl_i.found;
    ctrl_d       = ctrl_i;
    ctrl_d.found = ctrl_i.found | take;
    ctrl_d.live  = ctrl_i.valid & ~ctrl_i.ovf & (idx_i > IDX_W'(CELL_INDEX));
    rep_d        = take ? IDX_W'(PREV_INDEX) : rep_i;
  end

  assign store_en = adv_i & ctrl_i.valid & ~ctrl_i.ovf & (idx_i == IDX_W'(CELL_INDEX));

  for (genvar d = 0; d < STORE_DIMS; d++) begin : g_dim
    logic signed [COORD_BITS:0] diff;
    logic [COORD_BITS-1:0]      mag;

    assign diff    = {coord_i[d][COORD_BITS-1], coord_i[d]} - {pt_q[d][COORD_BITS-1], pt_q[d]};
    assign mag     = diff[COORD_BITS] ? COORD_BITS'(-diff) : diff[COORD_BITS-1:0];
    assign sq_d[d] = {{COORD_BITS{1'b0}}, mag} * {{COORD_BITS{1'b0}}, mag};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else if (adv_i) begin
      ctrl_q <= ctrl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      idx_q   <= idx_i;
      rep_q   <= rep_d;
      coord_q <= coord_i;
      sq_q    <= sq_d;
    end
    if (store_en) begin
      pt_q <= coord_i;
    end
  end

  assign ctrl_o  = ctrl_q;
  assign idx_o   = idx_q;
  assign rep_o   = rep_q;
  assign coord_o = coord_q;
  assign sq_o    = sq_q;

endmodule

// File: rtl/near_duplicate_point_finder.sv
// Each point item enters a chain of MAX_POINTS cells and moves one cell per clock unless the
// chain holds; cell k holds point k of the current set and squares its distance to the passing
// item, and the next stage adds the squares and compares them with the tolerance, so the lowest
// earlier match is kept as the representative. A result passes the cell registers and then the
// output register, and the chain takes one item every cycle; the whole chain shifts together
// and holds only while a result waits in the output register and is not taken. Points of a set
// beyond MAX_POINTS are flagged as overflow and not stored; the store needs no clearing.
module near_duplicate_point_finder #(
  parameter int MAX_POINTS = 64,
  parameter int COORD_BITS = 24,
  parameter int MAX_DIMS   = 3
) (
  input  logic clk_i,
  input  logic rst_ni,
  ndpf_pt_if.sink     point_i,
  ndpf_res_if.source  result_o,
  ndpf_cfg_if.sink    cfg_i
);
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int SQ_W       = 2 * COORD_BITS;
  localparam int STORE_DIMS = (MAX_DIMS < ndpf_pkg::FIELD_DIMS) ? MAX_DIMS
                                                                : ndpf_pkg::FIELD_DIMS;
  localparam int OUT_W      = ndpf_pkg::OUT_IDX_W;

  logic [ndpf_pkg::TOL_W-1:0]  tol_q;
  logic [ndpf_pkg::DIMS_W-1:0] dims_q;
  logic [ndpf_pkg::DIMS_W-1:0] dims_eff;
  logic [STORE_DIMS-1:0]       dim_en;

  logic [CNT_W-1:0] held_d, held_q;
  logic             full;
  logic             accept;
  logic             adv;

  ndpf_pkg::ctrl_t              ch_ctrl [MAX_POINTS+1];
  logic [IDX_W-1:0]             ch_idx  [MAX_POINTS+1];
  logic [IDX_W-1:0]             ch_rep  [MAX_POINTS+1];
  logic signed [COORD_BITS-1:0] ch_crd  [MAX_POINTS+1][STORE_DIMS];
  logic [SQ_W-1:0]              ch_sq   [MAX_POINTS+1][STORE_DIMS];

  logic             end_hit;
  logic [IDX_W-1:0] end_rep;

  logic                 out_valid_q;
  logic [OUT_W-1:0]     out_idx_q, out_rep_q;
  logic                 out_last_q, out_ovf_q;
  logic [IDX_W+OUT_W-1:0] idx_wide, rep_wide;

  // Register writes; the port never stalls.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q  <= '0;
      dims_q <= ndpf_pkg::DIMS_RESET;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        ndpf_pkg::REG_TOLERANCE: tol_q  <= cfg_i.data[ndpf_pkg::TOL_W-1:0];
        ndpf_pkg::REG_DIMS:      dims_q <= cfg_i.data[ndpf_pkg::DIMS_W-1:0];
        default: ;
      endcase
    end
  end

  // A dimension count of zero compares the first coordinate only.
  assign dims_eff = (dims_q == '0) ? ndpf_pkg::DIMS_W'(1) : dims_q;

  for (genvar d = 0; d < STORE_DIMS; d++) begin : g_en
    assign dim_en[d] = (ndpf_pkg::DIMS_W'(d) < dims_eff);
  end

  // The chain and the output register move together.
  assign adv           = ~out_valid_q | result_o.ready;
  assign point_i.ready = adv;
  assign accept        = point_i.valid & adv;

  assign full = (held_q >= CNT_W'(MAX_POINTS));

  always_comb begin
    held_d = held_q;
    if (accept) begin
      if (point_i.last_point) begin
        held_d = '0;
      end else if (!full) begin
        held_d = held_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
    end else begin
      held_q <= held_d;
    end
  end

  // Entry of the chain.
  always_comb begin
    ch_ctrl[0].valid = point_i.valid;
    ch_ctrl[0].last  = point_i.last_point;
    ch_ctrl[0].ovf   = full;
    ch_ctrl[0].found = 1'b0;
    ch_ctrl[0].live  = 1'b0;
    ch_idx[0]        = full ? IDX_W'(MAX_POINTS - 1) : held_q[IDX_W-1:0];
    ch_rep[0]        = ch_idx[0];
  end

  for (genvar d = 0; d < STORE_DIMS; d++) begin : g_entry
    if (d == 0) begin : g_x
      assign ch_crd[0][d] = point_i.coord_x;
    end else if (d == 1) begin : g_y
      assign ch_crd[0][d] = point_i.coord_y;
    end else begin : g_z
      assign ch_crd[0][d] = point_i.coord_z;
    end
    assign ch_sq[0][d] = '0;
  end

  for (genvar k = 0; k < MAX_POINTS; k++) begin : g_cell
    ndpf_cell #(
      .CELL_INDEX(k),
      .IDX_W     (IDX_W),
      .COORD_BITS(COORD_BITS),
      .STORE_DIMS(STORE_DIMS)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv),
      .tol_i   (tol_q),
      .dim_en_i(dim_en),
      .ctrl_i  (ch_ctrl[k]),
      .idx_i   (ch_idx[k]),
      .rep_i   (ch_rep[k]),
      .coord_i (ch_crd[k]),
      .sq_i    (ch_sq[k]),
      .ctrl_o  (ch_ctrl[k+1]),
      .idx_o   (ch_idx[k+1]),
      .rep_o   (ch_rep[k+1]),
      .coord_o (ch_crd[k+1]),
      .sq_o    (ch_sq[k+1])
    );
  end

  // The last cell's squares are tested here, just before the output register.
  ndpf_match #(
    .COORD_BITS(COORD_BITS),
    .STORE_DIMS(STORE_DIMS)
  ) u_end_match (
    .sq_i    (ch_sq[MAX_POINTS]),
    .dim_en_i(dim_en),
    .tol_i   (tol_q),
    .hit_o   (end_hit)
  );

  assign end_rep = (ch_ctrl[MAX_POINTS].live & end_hit & ~ch_ctrl[MAX_POINTS].found)
                   ? IDX_W'(MAX_POINTS - 1) : ch_rep[MAX_POINTS];

  assign idx_wide = {{OUT_W{1'b0}}, ch_idx[MAX_POINTS]};
  assign rep_wide = {{OUT_W{1'b0}}, end_rep};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= ch_ctrl[MAX_POINTS].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_idx_q  <= idx_wide[OUT_W-1:0];
      out_rep_q  <= rep_wide[OUT_W-1:0];
      out_last_q <= ch_ctrl[MAX_POINTS].last;
      out_ovf_q  <= ch_ctrl[MAX_POINTS].ovf;
    end
  end

  assign result_o.valid                = out_valid_q;
  assign result_o.point_index          = out_idx_q;
  assign result_o.representative_index = out_rep_q;
  assign result_o.set_done             = out_last_q;
  assign result_o.overflow             = out_ovf_q;

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench of the near-duplicate point finder with its own prediction of each result.
module tb_top;

  localparam int MAX_POINTS  = 64;
  localparam int COORD_W     = 24;
  localparam int LATENCY     = MAX_POINTS + 1;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_SPAN   = 400;

  localparam logic signed [COORD_W-1:0]        COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0]        COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
  localparam logic [ndpf_pkg::TOL_W-1:0]       TOL_MAX   = {ndpf_pkg::TOL_W{1'b1}};

  typedef struct {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic                      last;
  } point_t;

  typedef struct {
    logic [ndpf_pkg::OUT_IDX_W-1:0] pidx;
    logic [ndpf_pkg::OUT_IDX_W-1:0] ridx;
    logic                           done;
    logic                           ovf;
  } verdict_t;

  logic clk_i;
  logic rst_ni;

  ndpf_pt_if #(.COORD_BITS(COORD_W)) pt_if ();
  ndpf_res_if                        res_if ();
  ndpf_cfg_if                        cfg_if ();

  near_duplicate_point_finder #(
    .MAX_POINTS(MAX_POINTS),
    .COORD_BITS(COORD_W),
    .MAX_DIMS  (3)
  ) DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .point_i (pt_if),
    .result_o(res_if),
    .cfg_i   (cfg_if)
  );

  // Predicted state of the block: the points of the current set and the two registers.
  logic signed [COORD_W-1:0]      held_coords [MAX_POINTS][3];
  int                             held_count;
  logic [ndpf_pkg::TOL_W-1:0]     tol_sq;
  logic [ndpf_pkg::DIMS_W-1:0]    dims_cfg;

  verdict_t pending_verdicts [$];
  verdict_t due;

  int errors;
  int checked_count;
  int duplicate_count;
  int overflow_count;
  int sent_count;
  int config_count;
  int cycle_count;

  // Sender and receiver pacing, set by the test tasks.
  int gap_max;
  int burst_left;
  int stall_pct;
  int hold_serial;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Receiver: random stalls, with a long hold-off counted here whenever a test asks for one.
  initial begin
    int seen_serial;
    int hold_left;
    seen_serial = 0;
    hold_left   = 0;
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_serial != seen_serial) begin
        seen_serial = hold_serial;
        hold_left   = HOLD_SPAN;
      end
      if (hold_left > 0) begin
        hold_left    = hold_left - 1;
        res_if.ready = 1'b0;
      end else if (stall_pct == 0) begin
        res_if.ready = 1'b1;
      end else begin
        res_if.ready = ($urandom_range(99) >= stall_pct);
      end
    end
  end

  function automatic verdict_t classify_point(input point_t p);
    verdict_t                  v;
    logic signed [COORD_W-1:0] c [3];
    int                        dims;
    logic                      found;
    longint                    diff;
    logic [63:0]               span_sq;
    c[0]   = p.x;
    c[1]   = p.y;
    c[2]   = p.z;
    v.done = p.last;
    v.ovf  = 1'b0;
    dims   = (dims_cfg == 0) ? 1 : int'(dims_cfg);
    if (held_count >= MAX_POINTS) begin
      v.ovf  = 1'b1;
      v.pidx = ndpf_pkg::OUT_IDX_W'(MAX_POINTS - 1);
      v.ridx = ndpf_pkg::OUT_IDX_W'(MAX_POINTS - 1);
    end else begin
      v.pidx = ndpf_pkg::OUT_IDX_W'(held_count);
      v.ridx = ndpf_pkg::OUT_IDX_W'(held_count);
      found  = 1'b0;
      // At 24-bit coordinates the sum of squares stays below 2^52, so nothing saturates.
      for (int j = 0; j < held_count && !found; j++) begin
        span_sq = '0;
        for (int d = 0; d < dims; d++) begin
          diff = longint'(held_coords[j][d]) - longint'(c[d]);
          if (diff < 0) diff = -diff;
          span_sq = span_sq + 64'(diff * diff);
        end
        if (span_sq < {12'd0, tol_sq}) begin
          v.ridx = ndpf_pkg::OUT_IDX_W'(j);
          found  = 1'b1;
        end
      end
      for (int d = 0; d < 3; d++) held_coords[held_count][d] = c[d];
      held_count = held_count + 1;
    end
    if (p.last) held_count = 0;
    return v;
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (pending_verdicts.size() == 0) begin
        $error("result item with no expectation waiting");
        errors++;
      end else begin
        due = pending_verdicts.pop_front();
        check_field("point_index", due.pidx, res_if.point_index);
        check_field("representative_index", due.ridx, res_if.representative_index);
        check_field("set_done", due.done, res_if.set_done);
        check_field("overflow", due.ovf, res_if.overflow);
        checked_count++;
        if (due.ovf) overflow_count++;
        else if (due.ridx != due.pidx) duplicate_count++;
      end
    end
  end

  // Called and returning at a falling edge; the prediction is made as the item is accepted.
  task automatic send_point(input point_t p);
    verdict_t v;
    if (gap_max > 0 && burst_left == 0) begin
      pt_if.valid = 1'b0;
      repeat ($urandom_range(1, gap_max)) @(negedge clk_i);
      burst_left = $urandom_range(1, 24);
    end
    if (burst_left > 0) burst_left--;
    pt_if.valid      = 1'b1;
    pt_if.coord_x    = p.x;
    pt_if.coord_y    = p.y;
    pt_if.coord_z    = p.z;
    pt_if.last_point = p.last;
    @(posedge clk_i);
    while (!pt_if.ready) @(posedge clk_i);
    v = classify_point(p);
    pending_verdicts = {pending_verdicts, v};
    sent_count++;
    @(negedge clk_i);
  endtask

  task automatic send_coords(input int x, input int y, input int z, input logic last);
    point_t p;
    p.x    = COORD_W'(x);
    p.y    = COORD_W'(y);
    p.z    = COORD_W'(z);
    p.last = last;
    send_point(p);
  endtask

  task automatic drain_results();
    pt_if.valid = 1'b0;
    while (pending_verdicts.size() != 0) @(negedge clk_i);
  endtask

  // Only written with the block idle.
  task automatic write_register(input ndpf_pkg::reg_idx_e idx,
                                input logic [ndpf_pkg::CFG_DATA_W-1:0] value);
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data  = value;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    case (idx)
      ndpf_pkg::REG_TOLERANCE: tol_sq = value[ndpf_pkg::TOL_W-1:0];
      ndpf_pkg::REG_DIMS:      dims_cfg = value[ndpf_pkg::DIMS_W-1:0];
      default: ;
    endcase
    config_count++;
    @(negedge clk_i);
    cfg_if.valid = 1'b0;
  endtask

  task automatic send_random_set(input int count);
    point_t p;
    point_t sent [$];
    int     r;
    int     base_x;
    int     base_y;
    int     base_z;
    base_x = $urandom;
    base_y = $urandom;
    base_z = $urandom;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(99);
      if (sent.size() > 0 && r < 45) begin
        // Near copy of an earlier point of the set.
        p   = sent[$urandom_range(sent.size() - 1)];
        p.x = COORD_W'(p.x + (int'($urandom_range(6)) - 3));
        p.y = COORD_W'(p.y + (int'($urandom_range(6)) - 3));
        p.z = COORD_W'(p.z + (int'($urandom_range(6)) - 3));
      end else if (r < 85) begin
        p.x = COORD_W'(base_x + int'($urandom_range(400)) - 200);
        p.y = COORD_W'(base_y + int'($urandom_range(400)) - 200);
        p.z = COORD_W'(base_z + int'($urandom_range(400)) - 200);
      end else begin
        p.x = COORD_W'($urandom);
        p.y = COORD_W'($urandom);
        p.z = COORD_W'($urandom);
      end
      p.last = (k == count - 1);
      sent = {sent, p};
      send_point(p);
    end
  endtask

  task automatic test_directed();
    gap_max   = 0;
    stall_pct = 0;
    // Reset settings: zero tolerance, so even an exact copy is not a duplicate.
    send_coords(COORD_MAX, COORD_MAX, COORD_MAX, 1'b0);
    send_coords(COORD_MIN, COORD_MIN, COORD_MIN, 1'b0);
    send_coords(COORD_MAX, COORD_MAX, COORD_MAX, 1'b0);
    send_coords(0, 0, 0, 1'b1);
    send_coords(-1, -1, -1, 1'b1);
    drain_results();
    write_register(ndpf_pkg::REG_TOLERANCE, 52'd1);
    send_coords(5, -7, 9, 1'b0);
    send_coords(5, -7, 9, 1'b0);
    send_coords(5, -7, 10, 1'b1);
    drain_results();
    write_register(ndpf_pkg::REG_DIMS, 52'd1);
    send_coords(100, COORD_MAX, COORD_MIN, 1'b0);
    send_coords(100, COORD_MIN, COORD_MAX, 1'b1);
    drain_results();
    // A dimension count of zero compares the first coordinate only.
    write_register(ndpf_pkg::REG_DIMS, 52'd0);
    send_coords(-100, 1, 2, 1'b0);
    send_coords(-100, -2, -1, 1'b1);
    drain_results();
    write_register(ndpf_pkg::REG_DIMS, 52'd2);
    send_coords(100, 3, COORD_MIN, 1'b0);
    send_coords(100, 3, COORD_MAX, 1'b0);
    send_coords(100, 4, 0, 1'b1);
    drain_results();
    // The widest tolerance covers even opposite corners of the grid.
    write_register(ndpf_pkg::REG_TOLERANCE, TOL_MAX);
    write_register(ndpf_pkg::REG_DIMS, 52'd3);
    send_coords(COORD_MIN, COORD_MIN, COORD_MIN, 1'b0);
    send_coords(COORD_MAX, COORD_MAX, COORD_MAX, 1'b0);
    send_coords(COORD_MAX, COORD_MIN, 0, 1'b1);
    drain_results();
  endtask

  task automatic test_store_full();
    gap_max   = 4;
    stall_pct = 20;
    write_register(ndpf_pkg::REG_TOLERANCE, 52'd64);
    send_random_set(MAX_POINTS + 6);
    // Last point of the set arrives while the store is full.
    send_random_set(MAX_POINTS + 2);
    send_random_set(3);
    send_random_set(MAX_POINTS);
    drain_results();
  endtask

  task automatic test_backpressure();
    gap_max   = 0;
    stall_pct = 0;
    write_register(ndpf_pkg::REG_TOLERANCE, 52'd400);
    hold_serial++;
    for (int k = 0; k < 4; k++) send_random_set(40);
    drain_results();
  endtask

  task automatic test_random_sets();
    int sent_in_phase;
    int radius;
    for (int phase = 0; phase < 12; phase++) begin
      case (phase % 5)
        0: write_register(ndpf_pkg::REG_TOLERANCE, 52'd0);
        1: begin
          radius = $urandom_range(1, 16);
          write_register(ndpf_pkg::REG_TOLERANCE, ndpf_pkg::CFG_DATA_W'(radius * radius));
        end
        2: begin
          radius = $urandom_range(16, 400);
          write_register(ndpf_pkg::REG_TOLERANCE, ndpf_pkg::CFG_DATA_W'(radius * radius));
        end
        3: write_register(ndpf_pkg::REG_TOLERANCE,
                          ndpf_pkg::CFG_DATA_W'({$urandom, $urandom}));
        default: write_register(ndpf_pkg::REG_TOLERANCE, TOL_MAX);
      endcase
      write_register(ndpf_pkg::REG_DIMS, ndpf_pkg::CFG_DATA_W'(phase % 4));
      // The first phase runs with no idling on either side.
      gap_max   = (phase == 0) ? 0 : $urandom_range(1, 8);
      stall_pct = (phase == 0) ? 0 : $urandom_range(0, 70);
      sent_in_phase = 0;
      while (sent_in_phase < 100) begin
        radius = ($urandom_range(7) == 0) ? $urandom_range(17, MAX_POINTS)
                                          : $urandom_range(1, 16);
        send_random_set(radius);
        sent_in_phase += radius;
      end
      drain_results();
    end
  endtask

  initial begin
    rst_ni           = 1'b0;
    pt_if.valid      = 1'b0;
    pt_if.coord_x    = '0;
    pt_if.coord_y    = '0;
    pt_if.coord_z    = '0;
    pt_if.last_point = 1'b0;
    cfg_if.valid     = 1'b0;
    cfg_if.index     = ndpf_pkg::REG_TOLERANCE;
    cfg_if.data      = '0;
    held_count       = 0;
    tol_sq           = '0;
    dims_cfg         = ndpf_pkg::DIMS_RESET;
    errors           = 0;
    checked_count    = 0;
    duplicate_count  = 0;
    overflow_count   = 0;
    sent_count       = 0;
    config_count     = 0;
    cycle_count      = 0;
    gap_max          = 0;
    burst_left       = 0;
    stall_pct        = 0;
    hold_serial      = 0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed();
    test_store_full();
    test_backpressure();
    test_random_sets();

    drain_results();
    repeat (LATENCY + 8) @(posedge clk_i);
    if (pending_verdicts.size() != 0) begin
      $error("%0d expected results never arrived", pending_verdicts.size());
      errors++;
    end
    $display("Sent %0d points under %0d register writes; %0d results checked.",
             sent_count, config_count, checked_count);
    $display("%0d results named an earlier duplicate and %0d reported a full store.",
             duplicate_count, overflow_count);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
